/* design/bsti_pkg.sv */
// Package for the bounded sorted top-k insertion block.
// Holds field widths, the stored record type and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bsti_pkg;

    localparam int SCORE_W = 32;
    localparam int TIME_W  = 32;
    localparam int TAG_W   = 16;
    localparam int RANK_W  = 5;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [TIME_W-1:0]  stamp;
        logic [TAG_W-1:0]   tag;
    } t_rec;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_PUT,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

/* design/bsti_if.sv */
// Valid/ready channel interfaces for the input record and the result word.
// Depends on bsti_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bsti_in_if;
    import bsti_pkg::*;

    logic               valid;
    logic               ready;
    logic [SCORE_W-1:0] new_score;
    logic [TIME_W-1:0]  new_time;
    logic [TAG_W-1:0]   new_tag;

    modport source (output valid, output new_score, output new_time, output new_tag,
                    input ready);
    modport sink   (input valid, input new_score, input new_time, input new_tag,
                    output ready);
endinterface

interface bsti_out_if;
    import bsti_pkg::*;

    logic              valid;
    logic              ready;
    logic [RANK_W-1:0] rank;
    logic              kept;
    logic              evicted;
    logic [TAG_W-1:0]  evicted_tag;
    logic [RANK_W-1:0] fill_count;

    modport source (output valid, output rank, output kept, output evicted,
                    output evicted_tag, output fill_count, input ready);
    modport sink   (input valid, input rank, input kept, input evicted,
                    input evicted_tag, input fill_count, output ready);
endinterface

`default_nettype wire

/* design/bsti_cmp.sv */
// Shared rank comparator: tells whether a stored record ranks ahead of the new one.
// Depends on bsti_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

module bsti_cmp (
    input  wire logic [bsti_pkg::SCORE_W-1:0] i_slot_score,
    input  wire logic [bsti_pkg::TIME_W-1:0]  i_slot_time,
    input  wire logic [bsti_pkg::SCORE_W-1:0] i_new_score,
    input  wire logic [bsti_pkg::TIME_W-1:0]  i_new_time,
    output logic                              o_ahead
);
    import bsti_pkg::*;

    // higher score wins; on a tie the older or equal timestamp stays ahead
    always_comb begin
        o_ahead = (i_slot_score > i_new_score) ||
                  ((i_slot_score == i_new_score) && (i_slot_time <= i_new_time));
    end

endmodule

`default_nettype wire

/* design/bounded_sorted_topk_insert.sv */
// Sequence: an accepted word starts a scan from the tail entry toward the head; every
//   entry behind the new record moves down one slot, and the scan ends at an entry that
//   ranks ahead or past the head (no scan when empty). A dropped record skips the insert.
// Throughput: a record is taken only once the last result word is loaded; the scan, one
//   slot read and shifted per cycle, sets the pace; a stalled receiver adds its wait.
// Reset: fill count and control clear; table contents are never read past the fill count.
`timescale 1ns / 1ps
`default_nettype none

module bounded_sorted_topk_insert #(
    parameter int ENTRIES = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bsti_in_if.sink   i_in,
    bsti_out_if.source o_out
);
    import bsti_pkg::*;

    // address width for the table memory, count width that can hold ENTRIES itself
    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

    // table memory: one record per slot, sorted by descending rank
    t_rec          r_mem [ENTRIES];
    t_rec          r_rd_data;

    // sequencer and working registers
    t_state        r_state,   n_state;
    logic [AW-1:0] r_idx,     n_idx;
    logic [CW-1:0] r_pos,     n_pos;
    logic [CW-1:0] r_count,   n_count;
    t_rec          r_new,     n_new;
    logic          r_evicted, n_evicted;
    logic [TAG_W-1:0] r_ev_tag, n_ev_tag;
    logic          r_kept,    n_kept;

    // result word register
    logic              r_out_valid;
    logic [RANK_W-1:0] r_out_rank;
    logic              r_out_kept;
    logic              r_out_evicted;
    logic [TAG_W-1:0]  r_out_ev_tag;
    logic [RANK_W-1:0] r_out_fill;

    // memory port controls
    logic          we;
    logic [AW-1:0] waddr;
    t_rec          wdata;
    logic [AW-1:0] raddr;
    logic          in_ready;
    logic          load_out;
    logic          ahead;

    bsti_cmp u_cmp (
        .i_slot_score (r_rd_data.score),
        .i_slot_time  (r_rd_data.stamp),
        .i_new_score  (r_new.score),
        .i_new_time   (r_new.stamp),
        .o_ahead      (ahead)
    );

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rd_data <= r_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_pos     <= n_pos;
        r_new     <= n_new;
        r_evicted <= n_evicted;
        r_ev_tag  <= n_ev_tag;
        r_kept    <= n_kept;
    end

    // Scan from the tail toward the head. Each entry that ranks behind the new
    // record moves down one slot; the first one that ranks ahead ends the scan
    // and the new record lands just after it, unless that is past the last slot.
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_count   = r_count;
        n_new     = r_new;
        n_evicted = r_evicted;
        n_ev_tag  = r_ev_tag;
        n_kept    = r_kept;
        we        = 1'b0;
        waddr     = r_idx + AW'(1);
        wdata     = r_rd_data;
        in_ready  = 1'b0;
        load_out  = 1'b0;

        case (r_state)
            S_IDLE: begin
                // take no word while reset is held
                in_ready = i_rst_n;
                if (i_in.valid) begin
                    n_new.score = i_in.new_score;
                    n_new.stamp = i_in.new_time;
                    n_new.tag   = i_in.new_tag;
                    n_evicted   = 1'b0;
                    n_ev_tag    = '0;
                    n_kept      = 1'b1;
                    if (r_count == '0) begin
                        // empty table: place at the head at once
                        n_pos   = '0;
                        n_state = S_PUT;
                    end else begin
                        n_idx   = AW'(r_count - CW'(1));
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (ahead) begin
                    if (r_idx == LAST) begin
                        // full table and the new record ranks last: drop it
                        n_kept  = 1'b0;
                        n_pos   = CW'(ENTRIES);
                        n_state = S_EMIT;
                    end else begin
                        n_pos   = CW'(r_idx) + CW'(1);
                        n_state = S_PUT;
                    end
                end else begin
                    if (r_idx == LAST) begin
                        // the tail entry falls off the end
                        n_evicted = 1'b1;
                        n_ev_tag  = r_rd_data.tag;
                    end else begin
                        we    = 1'b1;
                        waddr = r_idx + AW'(1);
                        wdata = r_rd_data;
                    end
                    if (r_idx == '0) begin
                        n_pos   = '0;
                        n_state = S_PUT;
                    end else begin
                        n_idx = r_idx - AW'(1);
                    end
                end
            end
            S_PUT: begin
                we      = 1'b1;
                waddr   = r_pos[AW-1:0];
                wdata   = r_new;
                n_count = r_evicted ? r_count : r_count + CW'(1);
                n_state = S_EMIT;
            end
            S_EMIT: begin
                // hold until the result register is free
                if (!r_out_valid || o_out.ready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        raddr = n_idx;
    end

    // result word register: load on finish, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_rank    <= RANK_W'(r_pos);
            r_out_kept    <= r_kept;
            r_out_evicted <= r_evicted;
            r_out_ev_tag  <= r_ev_tag;
            r_out_fill    <= RANK_W'(r_count);
        end
    end

    assign i_in.ready        = in_ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.rank        = r_out_rank;
    assign o_out.kept        = r_out_kept;
    assign o_out.evicted     = r_out_evicted;
    assign o_out.evicted_tag = r_out_ev_tag;
    assign o_out.fill_count  = r_out_fill;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ENTRIES))
        else $error("fill count above table depth");

    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.evicted) |->
            (o_out.kept && (o_out.fill_count == RANK_W'(ENTRIES))))
        else $error("eviction reported without a full table and a kept record");

    a_drop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && n_state == S_EMIT) |=> (r_count == $past(r_count)))
        else $error("dropped record changed the fill count");

    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_EMIT) |-> !we)
        else $error("table written outside scan or insert");
`endif

endmodule

`default_nettype wire
